// File: sv/integer_to_radix_text_defines.svh
// Assertion macros shared by the integer_to_radix_text RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef INTEGER_TO_RADIX_TEXT_DEFINES_SVH
`define INTEGER_TO_RADIX_TEXT_DEFINES_SVH

// same-cycle implication
`define ITRT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("integer_to_radix_text: same-cycle check failed");

// next-cycle implication
`define ITRT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("integer_to_radix_text: next-cycle check failed");

`endif

// File: sv/itrt_pkg.sv
// Package for integer_to_radix_text: widths, character codes, register indexes.
// No dependencies.
`timescale 1ns / 1ps

package itrt_pkg;

    localparam int LP_IN_WIDTH    = 32;
    localparam int LP_VALUE_WIDTH = 32;
    localparam int LP_CHAR_W      = 7;
    localparam int LP_DIGIT_W     = 6;
    localparam int LP_CFG_W       = 6;
    localparam int LP_CFG_IDX_W   = 2;
    localparam int LP_CNT_W       = $clog2(LP_VALUE_WIDTH + 1);
    localparam int LP_ADDR_W      = $clog2(LP_VALUE_WIDTH);
    localparam int LP_DIV_BITS    = 8;
    localparam int LP_DIV_CYCLES  = (LP_VALUE_WIDTH + LP_DIV_BITS - 1) / LP_DIV_BITS;
    localparam int LP_DIV_W       = LP_DIV_CYCLES * LP_DIV_BITS;
    localparam int LP_STEP_W      = (LP_DIV_CYCLES > 1) ? $clog2(LP_DIV_CYCLES) : 1;

    localparam logic [LP_CHAR_W-1:0] LP_CHAR_ZERO        = 7'h30;
    localparam logic [LP_CHAR_W-1:0] LP_CHAR_LETTER_BASE = 7'h37;
    localparam logic [LP_CHAR_W-1:0] LP_CHAR_MINUS       = 7'h2D;

    localparam logic [LP_DIGIT_W-1:0] LP_RADIX_MIN = 6'd2;
    localparam logic [LP_DIGIT_W-1:0] LP_RADIX_MAX = 6'd36;

    localparam logic [LP_CFG_IDX_W-1:0] LP_CFG_RADIX      = 2'd0;
    localparam logic [LP_CFG_IDX_W-1:0] LP_CFG_MIN_DIGITS = 2'd1;
    localparam logic [LP_CFG_IDX_W-1:0] LP_CFG_SIGNED     = 2'd2;

    localparam logic [LP_DIGIT_W-1:0] LP_RST_RADIX      = 6'd10;
    localparam logic [LP_CFG_W-1:0]   LP_RST_MIN_DIGITS = 6'd1;

    typedef logic [LP_CHAR_W-1:0] t_char;

    function automatic t_char digit_char(input logic [LP_DIGIT_W-1:0] d);
        t_char c;
        if (d > LP_DIGIT_W'(9)) begin
            c = LP_CHAR_W'(d) + LP_CHAR_LETTER_BASE;
        end else begin
            c = LP_CHAR_W'(d) + LP_CHAR_ZERO;
        end
        return c;
    endfunction

endpackage

// File: sv/itrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module itrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/integer_to_radix_text.sv
// Sequence: take the value, then the divider makes each digit (8 quotient bits a cycle); each
// character then passes read, load and transfer; a minus sign only transfer, held on stall.
// Throughput: one item at a time; a new value is taken only after its last character is out.
// Reset (synchronous, i_rst_n low): radix 10, min_digits 1, signed mode, sequencer idle.
// The digit RAM is not cleared; padding zeros are generated, never read from it.
`timescale 1ns / 1ps
`include "integer_to_radix_text_defines.svh"

module integer_to_radix_text (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [itrt_pkg::LP_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [itrt_pkg::LP_CFG_W-1:0]    i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [itrt_pkg::LP_IN_WIDTH-1:0] i_value,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [itrt_pkg::LP_CHAR_W-1:0]   o_character,
    output logic                             o_last
);

    import itrt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_LD   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [LP_STEP_W-1:0] LP_STEP_LAST = LP_STEP_W'(LP_DIV_CYCLES - 1);
    localparam logic [LP_CNT_W-1:0]  LP_CNT_MAX   = LP_CNT_W'(LP_VALUE_WIDTH);

    // configuration
    logic [LP_DIGIT_W-1:0] r_radix;
    logic [LP_CFG_W-1:0]   r_min_digits;
    logic                  r_signed;

    // sequencer
    logic [2:0]            r_state, n_state;
    logic [LP_STEP_W-1:0]  r_step, n_step;
    logic [LP_CNT_W-1:0]   r_dcnt, n_dcnt;
    logic [LP_CNT_W-1:0]   r_idx, n_idx;
    logic [LP_CNT_W-1:0]   r_minlen, n_minlen;
    logic                  r_neg, n_neg;
    logic [LP_DIGIT_W-1:0] r_base, n_base;
    logic [LP_DIV_W-1:0]   r_mag, n_mag;
    logic [LP_DIGIT_W-1:0] r_rem, n_rem;
    t_char                 r_char, n_char;
    logic                  r_last, n_last;

    // shared divide unit
    logic [LP_DIV_W-1:0]   div_mag;
    logic [LP_DIGIT_W-1:0] div_rem;
    logic [LP_DIGIT_W:0]   div_part;

    // input preparation
    logic [LP_VALUE_WIDTH-1:0] in_bits;
    logic                      in_neg;
    logic [LP_VALUE_WIDTH-1:0] in_mag;
    logic [LP_CNT_W-1:0]       in_min;
    logic [LP_CNT_W-1:0]       dcnt_next;

    logic                  ram_we;
    logic [LP_DIGIT_W-1:0] ram_rdata;
    logic                  in_xfer;
    logic                  out_xfer;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_character = r_char;
    assign o_last      = r_last;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix      <= LP_RST_RADIX;
            r_min_digits <= LP_RST_MIN_DIGITS;
            r_signed     <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                LP_CFG_RADIX:      r_radix      <= i_cfg_data[LP_DIGIT_W-1:0];
                LP_CFG_MIN_DIGITS: r_min_digits <= i_cfg_data;
                LP_CFG_SIGNED:     r_signed     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // 8 restoring steps a cycle; dividend shifts out as quotient shifts in
    always_comb begin
        div_mag  = r_mag;
        div_rem  = r_rem;
        div_part = '0;
        for (int k = 0; k < LP_DIV_BITS; k++) begin
            div_part = {div_rem, div_mag[LP_DIV_W-1]};
            if (div_part >= {1'b0, r_base}) begin
                div_part = div_part - {1'b0, r_base};
                div_mag  = {div_mag[LP_DIV_W-2:0], 1'b1};
            end else begin
                div_mag  = {div_mag[LP_DIV_W-2:0], 1'b0};
            end
            div_rem = div_part[LP_DIGIT_W-1:0];
        end
    end

    always_comb begin
        in_bits = i_value[LP_VALUE_WIDTH-1:0];
        in_neg  = r_signed && in_bits[LP_VALUE_WIDTH-1];
        in_mag  = in_neg ? (~in_bits + LP_VALUE_WIDTH'(1)) : in_bits;
        in_min  = (LP_CNT_W'(r_min_digits) > LP_CNT_MAX) ? LP_CNT_MAX
                                                        : LP_CNT_W'(r_min_digits);
        if (in_neg && in_min != '0) begin
            in_min = in_min - LP_CNT_W'(1);
        end
    end

    assign dcnt_next = r_dcnt + LP_CNT_W'(1);

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_dcnt   = r_dcnt;
        n_idx    = r_idx;
        n_minlen = r_minlen;
        n_neg    = r_neg;
        n_base   = r_base;
        n_mag    = r_mag;
        n_rem    = r_rem;
        n_char   = r_char;
        n_last   = r_last;
        ram_we   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_mag    = LP_DIV_W'(in_mag);
                    n_neg    = in_neg;
                    n_minlen = in_min;
                    n_rem    = '0;
                    n_step   = '0;
                    n_dcnt   = '0;
                    if (r_radix < LP_RADIX_MIN) begin
                        n_base = LP_RADIX_MIN;
                    end else if (r_radix > LP_RADIX_MAX) begin
                        n_base = LP_RADIX_MAX;
                    end else begin
                        n_base = r_radix;
                    end
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_mag  = div_mag;
                n_rem  = div_rem;
                n_step = r_step + LP_STEP_W'(1);
                if (r_step == LP_STEP_LAST) begin
                    ram_we = 1'b1;
                    n_rem  = '0;
                    n_step = '0;
                    n_dcnt = dcnt_next;
                    if (div_mag == '0 || dcnt_next == LP_CNT_MAX) begin
                        n_idx = (dcnt_next > r_minlen) ? dcnt_next : r_minlen;
                        if (r_neg) begin
                            n_char  = LP_CHAR_MINUS;
                            n_last  = 1'b0;
                            n_state = S_OUT;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                n_char  = (r_idx > r_dcnt) ? LP_CHAR_ZERO : digit_char(ram_rdata);
                n_last  = (r_idx == LP_CNT_W'(1));
                n_idx   = r_idx - LP_CNT_W'(1);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_xfer) begin
                    n_state = (r_idx == '0) ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_dcnt  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_dcnt  <= n_dcnt;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_minlen <= n_minlen;
        r_neg    <= n_neg;
        r_base   <= n_base;
        r_mag    <= n_mag;
        r_rem    <= n_rem;
        r_char   <= n_char;
        r_last   <= n_last;
    end

    itrt_ram #(
        .WIDTH (LP_DIGIT_W),
        .DEPTH (LP_VALUE_WIDTH)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_dcnt[LP_ADDR_W-1:0]),
        .i_wdata (div_rem),
        .i_raddr (LP_ADDR_W'(r_idx - LP_CNT_W'(1))),
        .o_rdata (ram_rdata)
    );

    `ITRT_ASSERT_IMP(a_rem_below_base, r_state == S_DIV, r_rem < r_base)
    `ITRT_ASSERT_IMP(a_ld_has_char, r_state == S_LD || r_state == S_RD, r_idx != '0)
    `ITRT_ASSERT_NXT(a_last_ends_item, out_xfer && r_last, r_state == S_IDLE)
    `ITRT_ASSERT_IMP(a_dcnt_bound, r_state != S_IDLE, r_dcnt <= LP_CNT_MAX)

endmodule

// File: test/testbench.sv
// Testbench for integer_to_radix_text: drives integers, predicts the radix text and
// checks each output character and its last flag. Depends on itrt_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import itrt_pkg::*;

    typedef struct packed {
        t_char code;
        logic  last;
    } text_char_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                    cfg_valid = 1'b0;
    logic [LP_CFG_IDX_W-1:0] cfg_index = LP_CFG_RADIX;
    logic [LP_CFG_W-1:0]     cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic [LP_IN_WIDTH-1:0]  value = '0;
    logic                    out_stall = 1'b0;

    logic                    o_cfg_ready;
    logic                    o_in_stall;
    logic                    o_out_valid;
    t_char                   o_character;
    logic                    o_last;

    logic [LP_DIGIT_W-1:0]   radix_reg = LP_RST_RADIX;
    logic [LP_CFG_W-1:0]     min_digits_reg = LP_RST_MIN_DIGITS;
    logic                    signed_reg = 1'b1;

    logic [LP_IN_WIDTH-1:0]  pending_values[$];
    text_char_t              expected_text[$];
    int                      error_count = 0;
    int                      items_accepted = 0;
    logic                    idle_on = 1'b1;
    int                      tx_gap = 0;
    int                      rx_gap = 0;
    int                      hold_left = 0;
    logic                    hold_done = 1'b0;

    integer_to_radix_text uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (value),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Expected characters for one value under the current register settings.
    function automatic void predict_text(input logic [LP_IN_WIDTH-1:0] raw);
        logic [LP_VALUE_WIDTH-1:0] mag;
        logic [LP_VALUE_WIDTH-1:0] base;
        int                        minlen;
        int                        ndig;
        int                        digs[LP_VALUE_WIDTH + 1];
        logic                      neg;
        text_char_t                tc;
        mag = raw[LP_VALUE_WIDTH-1:0];
        base = LP_VALUE_WIDTH'(radix_reg);
        if (base < 2) base = 2;
        if (base > 36) base = 36;
        minlen = (min_digits_reg > LP_VALUE_WIDTH) ? LP_VALUE_WIDTH : int'(min_digits_reg);
        neg = signed_reg && mag[LP_VALUE_WIDTH-1];
        if (neg) begin
            mag = -mag;
            minlen = (minlen > 0) ? minlen - 1 : 0;
        end
        ndig = 0;
        do begin
            digs[ndig] = int'(mag % base);
            ndig++;
            mag = mag / base;
        end while (mag != 0 && ndig < LP_VALUE_WIDTH);
        while (ndig < minlen) begin
            digs[ndig] = 0;
            ndig++;
        end
        if (neg) begin
            tc.code = LP_CHAR_MINUS;
            tc.last = 1'b0;
            expected_text.push_back(tc);
        end
        for (int i = ndig - 1; i >= 0; i--) begin
            if (digs[i] > 9) begin
                tc.code = LP_CHAR_LETTER_BASE + LP_CHAR_W'(digs[i]);
            end else begin
                tc.code = LP_CHAR_ZERO + LP_CHAR_W'(digs[i]);
            end
            tc.last = (i == 0);
            expected_text.push_back(tc);
        end
    endfunction

    // Input driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_gap <= 0;
        end else begin
            if (in_valid && !o_in_stall) begin
                predict_text(value);
                items_accepted <= items_accepted + 1;
            end
            if (!in_valid || !o_in_stall) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    in_valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 9) == 0) begin
                    tx_gap <= $urandom_range(0, 11);
                    in_valid <= 1'b0;
                end else if (pending_values.size() != 0) begin
                    in_valid <= 1'b1;
                    value <= pending_values.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, once, to back the block up against its input
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && items_accepted >= 60) begin
            hold_left <= 600;
            hold_done <= 1'b1;
        end
    end

    // Output monitor
    always @(posedge clk) begin
        text_char_t exp_c;
        if (!rst_n) begin
            out_stall <= 1'b0;
            rx_gap <= 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_text.size() == 0) begin
                    report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                              o_character, o_last));
                end else begin
                    exp_c = expected_text.pop_front();
                    if (o_character !== exp_c.code) begin
                        report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                                  o_character, exp_c.code));
                    end
                    if (o_last !== exp_c.last) begin
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  o_last, exp_c.last));
                    end
                end
            end
            if (hold_left != 0) begin
                out_stall <= 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                rx_gap <= $urandom_range(0, 11);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic write_register(input logic [LP_CFG_IDX_W-1:0] idx,
                                  input logic [LP_CFG_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            LP_CFG_RADIX:      radix_reg = data;
            LP_CFG_MIN_DIGITS: min_digits_reg = data;
            LP_CFG_SIGNED:     signed_reg = data[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [LP_CFG_W-1:0] rdx, input logic [LP_CFG_W-1:0] mind,
                              input logic [LP_CFG_W-1:0] sgn);
        write_register(LP_CFG_RADIX, rdx);
        write_register(LP_CFG_MIN_DIGITS, mind);
        write_register(LP_CFG_SIGNED, sgn);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_values.size() != 0 || in_valid || expected_text.size() != 0) begin
            @(negedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [LP_IN_WIDTH-1:0] random_value();
        logic [LP_IN_WIDTH-1:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom_range(0, 100);
            1: v = ~LP_IN_WIDTH'($urandom_range(0, 999));
            2: v = LP_IN_WIDTH'(1) << $urandom_range(0, 31);
            3: v = ~(LP_IN_WIDTH'(1) << $urandom_range(0, 31));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    initial begin
        logic [LP_CFG_W-1:0] rdx;
        logic [LP_CFG_W-1:0] mind;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: decimal, signed, min one digit
        pending_values.push_back(32'h0000_0000);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'hFFFF_FFFF);
        pending_values.push_back(32'd12345);
        pending_values.push_back(32'hFFFF_CFC7);
        wait_drained();

        // binary, unsigned, full-width padding
        set_config(6'd2, 6'd32, 6'd0);
        @(negedge clk);
        pending_values.push_back(32'h0000_0000);
        pending_values.push_back(32'hFFFF_FFFF);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'd5);
        wait_drained();

        // base 36, signed, no padding room
        set_config(6'd36, 6'd0, 6'd1);
        @(negedge clk);
        pending_values.push_back(32'h0000_0000);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'hFFFF_FFFF);
        pending_values.push_back(32'd35);
        pending_values.push_back(32'h7FFF_FFFF);
        wait_drained();

        set_config(6'd16, 6'd1, 6'd1);
        @(negedge clk);
        pending_values.push_back(32'hFFFF_FF00);
        wait_drained();

        // radix below range, min digits beyond width: longest output
        set_config(6'd0, 6'd63, 6'd1);
        @(negedge clk);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'hFFFF_FFFF);
        wait_drained();

        // radix above range, sign register written with upper bits set
        set_config(6'd63, 6'd33, 6'h3E);
        @(negedge clk);
        pending_values.push_back(32'hFFFF_FFFF);
        wait_drained();

        set_config(6'd1, 6'd4, 6'h01);
        @(negedge clk);
        pending_values.push_back(32'hFFFF_FFFA);
        wait_drained();

        for (int ph = 0; ph < 12; ph++) begin
            rdx = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(2, 36));
            mind = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(0, 12));
            set_config(rdx, mind, 6'($urandom_range(0, 63)));
            @(negedge clk);
            idle_on = (ph == 11) ? 1'b0 : ($urandom_range(0, 3) != 0);
            for (int k = 0; k < 35; k++) begin
                pending_values.push_back(random_value());
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        while (expected_text.size() != 0) begin
            report_mismatch($sformatf("missing character 0x%02h", expected_text[0].code));
            void'(expected_text.pop_front());
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/itrt_pkg.sv
sv/itrt_ram.sv
sv/integer_to_radix_text.sv
test/testbench.sv
